>>> sv/sur_pkg.sv
// Shared constants, types and helper functions for the sound unit register file.
package sur_pkg;

    localparam int VOICE_COUNT  = 24;
    localparam int MEMORY_WORDS = 262144;
    localparam int REVERB_WORDS = 32;

    localparam int VOICE_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int MEM_AW  = $clog2(MEMORY_WORDS);
    localparam int REV_W   = (REVERB_WORDS > 1) ? $clog2(REVERB_WORDS) : 1;

    localparam logic [15:0] STATUS_MASK  = 16'hf800;
    localparam logic [15:0] SCRATCH_INIT = 16'h0004;
    localparam logic [13:0] PITCH_MAX    = 14'h3fff;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_VOL_L,
        OP_VOL_R,
        OP_PITCH,
        OP_START,
        OP_ENV1,
        OP_ENV2,
        OP_REPEAT,
        OP_REV_L,
        OP_REV_R,
        OP_IRQ,
        OP_XFER,
        OP_PORT,
        OP_CTRL,
        OP_SCRATCH,
        OP_STATUS
    } op_t;

    typedef struct packed {
        logic                wr;
        op_t                 op;
        logic                is_rev;
        logic [VOICE_W-1:0]  voice;
        logic [REV_W-1:0]    rev_idx;
        logic [15:0]         data;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    function automatic logic [16:0] vol_decode(input logic [15:0] v, input logic [2:0] flags);
        logic [15:0] w;
        logic [7:0]  h;
        logic [7:0]  lv;
        begin
            w = v;
            h = '0;
            lv = '0;
            if (v[15])
            begin
                if (v[12])
                begin
                    w = ~v;
                end
                h = ({1'b0, w[6:0]} + 8'd1) >> 1;
                if (v[13])
                begin
                    lv = h - (h >> 1);
                end
                else
                begin
                    lv = h + (h >> 1);
                end
                vol_decode = {v[13], v[14], 1'b1, lv[6:0], 7'd0};
            end
            else if (v[14])
            begin
                vol_decode = {flags[2:1], 1'b0, 14'h3fff - v[13:0]};
            end
            else
            begin
                vol_decode = {flags[2:1], 1'b0, v[13:0]};
            end
        end
    endfunction

    function automatic logic [15:0] vol_encode(input logic [13:0] lv, input logic [2:0] flags);
        begin
            if (flags[0])
            begin
                vol_encode = {1'b1, flags[1], flags[2], 6'd0, lv[6:0]};
            end
            else
            begin
                vol_encode = {2'b00, lv};
            end
        end
    endfunction

endpackage

>>> sv/sur_front.sv
// Front end: accepts request words and classifies them into commands.
module sur_front
    import sur_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [25:0] s_tdata,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic       wr;
    logic [8:0] off;
    cmd_t       c;

    assign wr  = s_tdata[0];
    assign off = s_tdata[9:1];

    always_comb
    begin
        c         = '0;
        c.wr      = wr;
        c.data    = s_tdata[25:10];
        c.op      = OP_NONE;
        c.voice   = VOICE_W'(off[7:3]);
        c.rev_idx = REV_W'(off[4:0]);
        if (off < 9'd192)
        begin
            if (32'(off[7:3]) < VOICE_COUNT)
            begin
                unique case (off[2:0])
                    3'd0: c.op = OP_VOL_L;
                    3'd1: c.op = OP_VOL_R;
                    3'd2: c.op = OP_PITCH;
                    3'd3: c.op = OP_START;
                    3'd4: c.op = OP_ENV1;
                    3'd5: c.op = OP_ENV2;
                    3'd7: c.op = OP_REPEAT;
                    default: c.op = OP_NONE;
                endcase
            end
        end
        else if (off < 9'd220)
        begin
            unique case (off - 9'd192)
                9'd2:  c.op = OP_REV_L;
                9'd3:  c.op = OP_REV_R;
                9'd18: c.op = OP_IRQ;
                9'd19: c.op = OP_XFER;
                9'd20: c.op = OP_PORT;
                9'd21: c.op = OP_CTRL;
                9'd22: c.op = OP_SCRATCH;
                9'd23: c.op = OP_STATUS;
                default: c.op = OP_NONE;
            endcase
        end
        else if (off >= 9'd224 && off < 9'd256)
        begin
            c.is_rev = (32'(off[4:0]) < REVERB_WORDS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else if (s_tready)
        begin
            cmd_valid <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            cmd <= c;
        end
    end

    assign s_tready = !cmd_valid || cmd_ready;

endmodule

>>> sv/sur_queue.sv
// Two-entry queue that decouples the front end from the back end.
module sur_queue
    import sur_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not grow");

endmodule

>>> sv/sur_back.sv
// Back end: register storage, sound memory and read data formation.
module sur_back
    import sur_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    logic [13:0] l_lvl_reg [VOICE_COUNT];
    logic [2:0]  l_flg_reg [VOICE_COUNT];
    logic [13:0] r_lvl_reg [VOICE_COUNT];
    logic [2:0]  r_flg_reg [VOICE_COUNT];
    logic [13:0] pitch_reg [VOICE_COUNT];
    logic [15:0] start_reg [VOICE_COUNT];
    logic [15:0] env1_reg  [VOICE_COUNT];
    logic [15:0] env2_reg  [VOICE_COUNT];
    logic [15:0] rpt_reg   [VOICE_COUNT];
    logic [15:0] rev_reg   [REVERB_WORDS];
    logic [15:0] rdl_reg;
    logic [15:0] rdr_reg;
    logic [15:0] irq_reg;
    logic [18:0] xfer_reg;
    logic [15:0] ctrl_reg;
    logic [15:0] scr_reg;
    logic [15:0] stat_reg;
    logic [15:0] smem [MEMORY_WORDS];

    // The sound memory read register and the output data register load together; m_tdata picks one.
    logic        p_valid_reg;
    logic        p_mem_reg;
    logic [15:0] p_data_reg;
    logic [15:0] mem_q_reg;
    logic        adv;
    logic        take;
    logic [15:0] rd;
    logic [16:0] vl;
    logic [16:0] vr;
    logic [MEM_AW-1:0] midx;
    logic [VOICE_W-1:0] v;

    assign adv       = !m_tvalid || m_tready;
    assign cmd_ready = adv;
    assign take      = cmd_valid && cmd_ready;
    assign v         = cmd.voice;
    assign midx      = MEM_AW'(xfer_reg[18:1]);
    assign vl        = vol_decode(cmd.data, l_flg_reg[v]);
    assign vr        = vol_decode(cmd.data, r_flg_reg[v]);
    assign m_tvalid  = p_valid_reg;
    assign m_tdata   = p_mem_reg ? mem_q_reg : p_data_reg;

    always_comb
    begin
        rd = '0;
        if (cmd.is_rev)
        begin
            rd = rev_reg[cmd.rev_idx];
        end
        unique case (cmd.op)
            OP_VOL_L:   rd = vol_encode(l_lvl_reg[v], l_flg_reg[v]);
            OP_VOL_R:   rd = vol_encode(r_lvl_reg[v], r_flg_reg[v]);
            OP_PITCH:   rd = {2'b00, pitch_reg[v]};
            OP_START:   rd = start_reg[v];
            OP_ENV1:    rd = env1_reg[v];
            OP_ENV2:    rd = env2_reg[v] & 16'hdfff;
            OP_REPEAT:  rd = rpt_reg[v];
            OP_REV_L:   rd = rdl_reg;
            OP_REV_R:   rd = rdr_reg;
            OP_IRQ:     rd = irq_reg;
            OP_XFER:    rd = xfer_reg[18:3];
            OP_CTRL:    rd = ctrl_reg;
            OP_SCRATCH: rd = scr_reg;
            OP_STATUS:  rd = stat_reg;
            default:    ;
        endcase
        if (cmd.wr)
        begin
            rd = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_mem_reg   <= 1'b0;
            p_data_reg  <= '0;
            rdl_reg     <= '0;
            rdr_reg     <= '0;
            irq_reg     <= '0;
            xfer_reg    <= '0;
            ctrl_reg    <= '0;
            scr_reg     <= SCRATCH_INIT;
            stat_reg    <= '0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                l_lvl_reg[i] <= '0;
                l_flg_reg[i] <= '0;
                r_lvl_reg[i] <= '0;
                r_flg_reg[i] <= '0;
                pitch_reg[i] <= '0;
                start_reg[i] <= '0;
                env1_reg[i]  <= '0;
                env2_reg[i]  <= '0;
                rpt_reg[i]   <= '0;
            end
            for (int i = 0; i < REVERB_WORDS; i++)
            begin
                rev_reg[i] <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                p_valid_reg <= cmd_valid;
                p_mem_reg   <= take && (cmd.op == OP_PORT) && !cmd.wr;
                p_data_reg  <= rd;
            end
            if (take && cmd.op == OP_PORT)
            begin
                xfer_reg <= xfer_reg + 19'd2;
            end
            if (take && cmd.wr)
            begin
                if (cmd.is_rev)
                begin
                    rev_reg[cmd.rev_idx] <= cmd.data;
                end
                unique case (cmd.op)
                    OP_VOL_L:
                    begin
                        l_lvl_reg[v] <= vl[13:0];
                        l_flg_reg[v] <= vl[16:14];
                    end
                    OP_VOL_R:
                    begin
                        r_lvl_reg[v] <= vr[13:0];
                        r_flg_reg[v] <= vr[16:14];
                    end
                    OP_PITCH:   pitch_reg[v] <= (cmd.data > 16'h3fff) ? PITCH_MAX
                                                                       : cmd.data[13:0];
                    OP_START:   start_reg[v] <= cmd.data;
                    OP_ENV1:    env1_reg[v]  <= cmd.data;
                    OP_ENV2:    env2_reg[v]  <= cmd.data;
                    OP_REPEAT:  rpt_reg[v]   <= cmd.data;
                    OP_REV_L:   rdl_reg      <= cmd.data;
                    OP_REV_R:   rdr_reg      <= cmd.data;
                    OP_IRQ:     irq_reg      <= cmd.data;
                    OP_XFER:    xfer_reg     <= {cmd.data, 3'd0};
                    OP_CTRL:    ctrl_reg     <= cmd.data;
                    OP_SCRATCH: scr_reg      <= cmd.data;
                    OP_STATUS:  stat_reg     <= cmd.data & STATUS_MASK;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.op == OP_PORT)
        begin
            if (cmd.wr)
            begin
                smem[midx] <= cmd.data;
            end
            else
            begin
                mem_q_reg <= smem[midx];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.wr) |=> (m_tdata == 16'd0))
        else $error("write answered with nonzero data");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd.op == OP_PORT && cmd.op != OP_XFER) |=>
        (xfer_reg == $past(xfer_reg) + 19'd2))
        else $error("transfer pointer did not step");

endmodule

>>> sv/sound_unit_register_file.sv
// Path: front end command register, queue entry, then the back end output register.
// Throughput: one word per cycle when not stalled; the output register and a two-entry
// queue decouple the sides, and each access touches one register or one sound memory word.
// Reset: asynchronous active low; all register file registers clear, scratch reads 4,
// and sound memory contents stay undefined until written.
// Top level of the sound unit register file.
module sound_unit_register_file
    import sur_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_type, reg_offset[8:0], write_data[15:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[15:0]
);

    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    sur_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata[25:0]),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    sur_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    sur_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
